// ===== design/cce_pkg.sv =====
// ----------------------------------------------------------------------------
// Consider covariance engine package
// Sizes, address widths, item codes and the shared floating-point unit's
// request and response types.
// ----------------------------------------------------------------------------
package cce_pkg;

  localparam int MAX_STATES    = 8;
  localparam int MAX_CONSIDERS = 4;

  localparam int MAX_DIM = (MAX_STATES > MAX_CONSIDERS) ? MAX_STATES : MAX_CONSIDERS;
  localparam int IDXW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  localparam int COV_DEPTH = MAX_STATES * MAX_STATES;
  localparam int COVAW     = (COV_DEPTH > 1) ? $clog2(COV_DEPTH) : 1;
  localparam int CON_DEPTH = MAX_CONSIDERS * MAX_CONSIDERS;
  localparam int CONAW     = (CON_DEPTH > 1) ? $clog2(CON_DEPTH) : 1;
  localparam int ACC_DEPTH = MAX_STATES * MAX_CONSIDERS;
  localparam int ACCAW     = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
  localparam int HXAW      = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int HCAW      = (MAX_CONSIDERS > 1) ? $clog2(MAX_CONSIDERS) : 1;

  localparam logic [1:0] REG_STATES    = 2'd0;
  localparam logic [1:0] REG_CONSIDERS = 2'd1;

  typedef enum logic [2:0] {
    KIND_P      = 3'd0,
    KIND_C      = 3'd1,
    KIND_HX     = 3'd2,
    KIND_HC     = 3'd3,
    KIND_COMMIT = 3'd4,
    KIND_FINISH = 3'd5
  } kind_t;

  localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

  typedef enum logic {
    FOP_MUL = 1'b0,
    FOP_ADD = 1'b1
  } fpu_op_t;

  typedef struct packed {
    logic        start;
    fpu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } fpu_rsp_t;

endpackage

// ===== design/consider_covariance_engine.sv =====
// Work: a weight commit runs n*(c+1) multiplies and n*c adds, a finish
// n*c*(2n+c) multiply-adds plus n*n final adds, all through the single
// shared FPU. Items are taken one at a time: no new item is accepted until
// the last one is through, as set by that one iterative FPU.
// Reset: synchronous; sizes return to 8 and 4, the cross accumulator reads as
// zero, P, C and the row buffers are undefined until written.
// ----------------------------------------------------------------------------
// Consider covariance engine
// Loads P and C, accumulates M from weighted observation rows, and on finish
// streams P + T*C*T^T with T = P*M, one element per transfer.
// ----------------------------------------------------------------------------
module consider_covariance_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [2:0]  row_index,
  input  logic [2:0]  col_index,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_row,
  output logic [2:0]  out_col,
  output logic [63:0] out_value,
  output logic        last_of_run,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_MUL, S_MULW, S_ADD, S_FIN, S_ADDW, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PH_HW, PH_COMMIT, PH_T, PH_S, PH_OUT
  } phase_t;

  state_t state;
  phase_t phase;

  logic [3:0] states_in_use;
  logic [2:0] considers_in_use;
  logic [cce_pkg::IDXW-1:0] i, j, k, n_last, c_last;
  logic [63:0] v_reg, hw, prod, acc;
  logic fin;
  logic [cce_pkg::ACC_DEPTH-1:0] m_valid;

  logic [63:0] cov_mem [cce_pkg::COV_DEPTH];
  logic [63:0] con_mem [cce_pkg::CON_DEPTH];
  logic [63:0] m_mem   [cce_pkg::ACC_DEPTH];
  logic [63:0] t_mem   [cce_pkg::ACC_DEPTH];
  logic [63:0] s_mem   [cce_pkg::ACC_DEPTH];
  logic [63:0] hx_buf  [cce_pkg::MAX_STATES];
  logic [63:0] hc_buf  [cce_pkg::MAX_CONSIDERS];

  logic [cce_pkg::COVAW-1:0] cov_ra, cov_wa;
  logic [cce_pkg::CONAW-1:0] con_ra, con_wa;
  logic [cce_pkg::ACCAW-1:0] m_ra, m_wa, t_ra, t_wa, s_ra, s_wa;
  logic [cce_pkg::HXAW-1:0]  hx_ra, hx_wa;
  logic [cce_pkg::HCAW-1:0]  hc_ra, hc_wa;
  logic cov_we, con_we, m_we, t_we, s_we, hx_we, hc_we;
  logic [63:0] cov_q, con_q, m_d, t_q, s_q, hx_q, hc_q, m_q;
  logic m_vq;

  logic accept, row_ok_p, col_ok_p, row_ok_c, col_ok_c, fpu_done;
  logic [63:0] mul_x, mul_y, add_z, r;

  cce_pkg::fpu_req_t fpu_req;
  cce_pkg::fpu_rsp_t fpu_rsp;

  cce_fpu u_fpu (
    .clk (clk),
    .rst (rst),
    .req (fpu_req),
    .rsp (fpu_rsp)
  );

  assign fpu_done = fpu_rsp.done;
  assign r        = fpu_rsp.result;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Effective sizes, clamped into 1..MAX, held as the last index.
  always_comb begin
    if (int'(states_in_use) > cce_pkg::MAX_STATES) begin
      n_last = cce_pkg::IDXW'(cce_pkg::MAX_STATES - 1);
    end else if (states_in_use == '0) begin
      n_last = '0;
    end else begin
      n_last = cce_pkg::IDXW'(states_in_use - 4'd1);
    end
    if (int'(considers_in_use) > cce_pkg::MAX_CONSIDERS) begin
      c_last = cce_pkg::IDXW'(cce_pkg::MAX_CONSIDERS - 1);
    end else if (considers_in_use == '0) begin
      c_last = '0;
    end else begin
      c_last = cce_pkg::IDXW'(considers_in_use - 3'd1);
    end
  end

  assign row_ok_p = int'(row_index) < cce_pkg::MAX_STATES;
  assign col_ok_p = int'(col_index) < cce_pkg::MAX_STATES;
  assign row_ok_c = int'(row_index) < cce_pkg::MAX_CONSIDERS;
  assign col_ok_c = int'(col_index) < cce_pkg::MAX_CONSIDERS;

  always_comb begin
    cov_we = 1'b0;
    con_we = 1'b0;
    hx_we  = 1'b0;
    hc_we  = 1'b0;
    if (accept) begin
      case (cce_pkg::kind_t'(kind))
        cce_pkg::KIND_P:  cov_we = row_ok_p && col_ok_p;
        cce_pkg::KIND_C:  con_we = row_ok_c && col_ok_c;
        cce_pkg::KIND_HX: hx_we  = col_ok_p;
        cce_pkg::KIND_HC: hc_we  = col_ok_c;
        default: ;
      endcase
    end
  end

  assign cov_wa = cce_pkg::COVAW'(int'(row_index) * cce_pkg::MAX_STATES + int'(col_index));
  assign con_wa = cce_pkg::CONAW'(int'(row_index) * cce_pkg::MAX_CONSIDERS + int'(col_index));
  assign hx_wa  = cce_pkg::HXAW'(col_index);
  assign hc_wa  = cce_pkg::HCAW'(col_index);

  assign m_we = (state == S_ADDW) && fpu_done && (phase == PH_COMMIT);
  assign t_we = (state == S_ADDW) && fpu_done && (phase == PH_T) && (k == n_last);
  assign s_we = (state == S_ADDW) && fpu_done && (phase == PH_S) && (k == c_last);
  assign m_wa = cce_pkg::ACCAW'(int'(i) * cce_pkg::MAX_CONSIDERS + int'(j));
  assign t_wa = m_wa;
  assign s_wa = m_wa;

  // Read addresses follow the phase and loop indices; the read data is registered and lands in the next cycle.
  always_comb begin
    cov_ra = (phase == PH_T) ? cce_pkg::COVAW'(int'(i) * cce_pkg::MAX_STATES + int'(k))
                             : cce_pkg::COVAW'(int'(i) * cce_pkg::MAX_STATES + int'(j));
    m_ra   = (phase == PH_T) ? cce_pkg::ACCAW'(int'(k) * cce_pkg::MAX_CONSIDERS + int'(j))
                             : cce_pkg::ACCAW'(int'(i) * cce_pkg::MAX_CONSIDERS + int'(j));
    t_ra   = (phase == PH_OUT) ? cce_pkg::ACCAW'(int'(j) * cce_pkg::MAX_CONSIDERS + int'(k))
                               : cce_pkg::ACCAW'(int'(i) * cce_pkg::MAX_CONSIDERS + int'(k));
    s_ra   = cce_pkg::ACCAW'(int'(i) * cce_pkg::MAX_CONSIDERS + int'(k));
    con_ra = cce_pkg::CONAW'(int'(k) * cce_pkg::MAX_CONSIDERS + int'(j));
    hx_ra  = cce_pkg::HXAW'(i);
    hc_ra  = cce_pkg::HCAW'(j);
  end

  always_ff @(posedge clk) begin
    if (cov_we) cov_mem[cov_wa] <= value;
    cov_q <= cov_mem[cov_ra];
  end

  always_ff @(posedge clk) begin
    if (con_we) con_mem[con_wa] <= value;
    con_q <= con_mem[con_ra];
  end

  always_ff @(posedge clk) begin
    if (m_we) m_mem[m_wa] <= r;
    m_d <= m_mem[m_ra];
  end

  always_ff @(posedge clk) begin
    if (t_we) t_mem[t_wa] <= r;
    t_q <= t_mem[t_ra];
  end

  always_ff @(posedge clk) begin
    if (s_we) s_mem[s_wa] <= r;
    s_q <= s_mem[s_ra];
  end

  always_ff @(posedge clk) begin
    if (hx_we) hx_buf[hx_wa] <= value;
    hx_q <= hx_buf[hx_ra];
  end

  always_ff @(posedge clk) begin
    if (hc_we) hc_buf[hc_wa] <= value;
    hc_q <= hc_buf[hc_ra];
  end

  assign m_q = m_vq ? m_d : 64'd0;

  always_comb begin
    case (phase)
      PH_HW:     begin mul_x = hx_q;  mul_y = v_reg; add_z = acc; end
      PH_COMMIT: begin mul_x = hw;    mul_y = hc_q;  add_z = m_q; end
      PH_T:      begin mul_x = cov_q; mul_y = m_q;   add_z = acc; end
      PH_S:      begin mul_x = t_q;   mul_y = con_q; add_z = acc; end
      PH_OUT:    begin mul_x = s_q;   mul_y = t_q;   add_z = acc; end
      default:   begin mul_x = '0;    mul_y = '0;    add_z = '0;  end
    endcase
  end

  always_comb begin
    fpu_req.start = (state == S_MUL) || (state == S_ADD) || (state == S_FIN);
    fpu_req.op    = (state == S_MUL) ? cce_pkg::FOP_MUL : cce_pkg::FOP_ADD;
    fpu_req.a     = (state == S_MUL) ? mul_x : ((state == S_FIN) ? cov_q : add_z);
    fpu_req.b     = (state == S_MUL) ? mul_y : ((state == S_FIN) ? acc : prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      phase            <= PH_HW;
      out_valid        <= 1'b0;
      m_valid          <= '0;
      fin              <= 1'b0;
      i                <= '0;
      j                <= '0;
      k                <= '0;
      states_in_use    <= 4'd8;
      considers_in_use <= 3'd4;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          cce_pkg::REG_STATES:    states_in_use    <= cfg_data;
          cce_pkg::REG_CONSIDERS: considers_in_use <= cfg_data[2:0];
          default: ;
        endcase
      end
      m_vq <= m_valid[m_ra];
      if (m_we) m_valid[m_wa] <= 1'b1;

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cce_pkg::kind_t'(kind))
              cce_pkg::KIND_COMMIT: begin
                v_reg <= value;
                phase <= PH_HW;
                i     <= '0;
                j     <= '0;
                state <= S_READ;
              end
              cce_pkg::KIND_FINISH: begin
                phase <= PH_T;
                i     <= '0;
                j     <= '0;
                k     <= '0;
                acc   <= '0;
                fin   <= 1'b0;
                state <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: state <= S_MUL;
        S_MUL:  state <= S_MULW;
        S_MULW: begin
          if (fpu_done) begin
            if (phase == PH_HW) begin
              hw    <= r;
              phase <= PH_COMMIT;
              j     <= '0;
              state <= S_READ;
            end else begin
              prod  <= r;
              state <= S_ADD;
            end
          end
        end
        S_ADD: state <= S_ADDW;
        S_FIN: state <= S_ADDW;
        S_ADDW: begin
          if (fpu_done) begin
            case (phase)
              PH_COMMIT: begin
                if (j == c_last) begin
                  j <= '0;
                  if (i == n_last) begin
                    i     <= '0;
                    state <= S_IDLE;
                  end else begin
                    i     <= i + cce_pkg::IDXW'(1);
                    phase <= PH_HW;
                    state <= S_READ;
                  end
                end else begin
                  j     <= j + cce_pkg::IDXW'(1);
                  state <= S_READ;
                end
              end
              PH_T: begin
                state <= S_READ;
                if (k == n_last) begin
                  acc <= '0;
                  k   <= '0;
                  if (j == c_last) begin
                    j <= '0;
                    if (i == n_last) begin
                      i     <= '0;
                      phase <= PH_S;
                    end else begin
                      i <= i + cce_pkg::IDXW'(1);
                    end
                  end else begin
                    j <= j + cce_pkg::IDXW'(1);
                  end
                end else begin
                  acc <= r;
                  k   <= k + cce_pkg::IDXW'(1);
                end
              end
              PH_S: begin
                state <= S_READ;
                if (k == c_last) begin
                  acc <= '0;
                  k   <= '0;
                  if (j == c_last) begin
                    j <= '0;
                    if (i == n_last) begin
                      i     <= '0;
                      phase <= PH_OUT;
                    end else begin
                      i <= i + cce_pkg::IDXW'(1);
                    end
                  end else begin
                    j <= j + cce_pkg::IDXW'(1);
                  end
                end else begin
                  acc <= r;
                  k   <= k + cce_pkg::IDXW'(1);
                end
              end
              PH_OUT: begin
                if (fin) begin
                  out_row     <= 3'(i);
                  out_col     <= 3'(j);
                  out_value   <= r;
                  last_of_run <= (i == n_last) && (j == n_last);
                  out_valid   <= 1'b1;
                  state       <= S_EMIT;
                end else begin
                  acc <= r;
                  if (k == c_last) begin
                    // The P entry address has been stable since this element began.
                    fin   <= 1'b1;
                    state <= S_FIN;
                  end else begin
                    k     <= k + cce_pkg::IDXW'(1);
                    state <= S_READ;
                  end
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            fin       <= 1'b0;
            acc       <= '0;
            k         <= '0;
            if (j == n_last) begin
              j <= '0;
              if (i == n_last) begin
                i       <= '0;
                m_valid <= '0;
                state   <= S_IDLE;
              end else begin
                i     <= i + cce_pkg::IDXW'(1);
                state <= S_READ;
              end
            end else begin
              j     <= j + cce_pkg::IDXW'(1);
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The block never takes an item while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // The FPU only answers while the sequencer waits for it.
  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    fpu_done |-> (state == S_MULW || state == S_ADDW))
    else $error("FPU result arrived outside a wait state");

  // A start request lasts one cycle.
  a_start_pulse: assert property (@(posedge clk) disable iff (rst)
    fpu_req.start |=> !fpu_req.start)
    else $error("FPU start held for more than one cycle");

  // After the last element transfers, the block is ready again.
  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_of_run) |=> in_ready)
    else $error("block not idle after the final element");

endmodule

// ===== design/cce_fpu.sv =====
// ----------------------------------------------------------------------------
// Iterative binary64 multiply / add unit
// Round to nearest even with subnormals; the product is built from four
// 27 by 27 partial products and normalization shifts left by 16 bits while the top 16 are clear, else by one bit.
// ----------------------------------------------------------------------------
module cce_fpu (
  input  logic              clk,
  input  logic              rst,
  input  cce_pkg::fpu_req_t req,
  output cce_pkg::fpu_rsp_t rsp
);

  typedef enum logic [2:0] {
    F_IDLE, F_CHECK, F_PROD, F_ALIGN, F_NORM, F_SHIFT, F_ROUND, F_DONE
  } fstate_t;

  fstate_t              state;
  cce_pkg::fpu_op_t     op_r;
  logic [63:0]          a_r, b_r, res;
  logic [127:0]         w, w2;
  logic signed [13:0]   x;
  logic                 sgn, sgn_small, sub;
  logic [2:0]           cnt;
  logic [53:0]          pp;
  logic [1:0]           pp_sh;
  logic                 stk;
  logic [10:0]          expm1;

  logic [10:0] ea, eb, effa, effb, effbig, effsmall, d;
  logic [51:0] fa, fb;
  logic [52:0] ma, mb, mbig, msmall;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, mul_sign, a_big;
  logic        spec_hit;
  logic [63:0] spec_val;
  logic [127:0] small_w0, small_al, pp_w;
  logic [26:0] pa, pb;
  logic signed [13:0] be, sh;
  logic [52:0] mant;
  logic        rnd_up;
  logic [62:0] mag;

  assign ea = a_r[62:52];
  assign eb = b_r[62:52];
  assign fa = a_r[51:0];
  assign fb = b_r[51:0];
  assign a_nan  = (ea == 11'h7FF) && (fa != '0);
  assign b_nan  = (eb == 11'h7FF) && (fb != '0);
  assign a_inf  = (ea == 11'h7FF) && (fa == '0);
  assign b_inf  = (eb == 11'h7FF) && (fb == '0);
  assign a_zero = (ea == '0) && (fa == '0);
  assign b_zero = (eb == '0) && (fb == '0);
  assign ma   = {ea != '0, fa};
  assign mb   = {eb != '0, fb};
  assign effa = (ea == '0) ? 11'd1 : ea;
  assign effb = (eb == '0) ? 11'd1 : eb;
  assign mul_sign = a_r[63] ^ b_r[63];

  // Operand with the larger exponent leads the alignment.
  assign a_big    = (effa >= effb);
  assign effbig   = a_big ? effa : effb;
  assign effsmall = a_big ? effb : effa;
  assign mbig     = a_big ? ma : mb;
  assign msmall   = a_big ? mb : ma;
  assign d        = effbig - effsmall;
  assign small_w0 = {2'b00, msmall, 73'b0};

  always_comb begin
    if (d[10:7] != '0) begin
      small_al = 128'd1;
    end else begin
      small_al = (small_w0 >> d[6:0]) |
                 128'((small_w0 & ~({128{1'b1}} << d[6:0])) != '0);
    end
  end

  always_comb begin
    spec_hit = 1'b1;
    spec_val = '0;
    if (a_nan) begin
      spec_val = a_r | cce_pkg::QUIET_BIT;
    end else if (b_nan) begin
      spec_val = b_r | cce_pkg::QUIET_BIT;
    end else if (op_r == cce_pkg::FOP_MUL) begin
      if ((a_inf && b_zero) || (a_zero && b_inf)) spec_val = cce_pkg::DEFAULT_NAN;
      else if (a_inf || b_inf) spec_val = {mul_sign, 11'h7FF, 52'b0};
      else if (a_zero || b_zero) spec_val = {mul_sign, 63'b0};
      else spec_hit = 1'b0;
    end else begin
      if (a_inf && b_inf && (a_r[63] != b_r[63])) spec_val = cce_pkg::DEFAULT_NAN;
      else if (a_inf) spec_val = a_r;
      else if (b_inf) spec_val = b_r;
      else if (a_zero && b_zero) spec_val = {a_r[63] & b_r[63], 63'b0};
      else if (a_zero) spec_val = b_r;
      else if (b_zero) spec_val = a_r;
      else spec_hit = 1'b0;
    end
  end

  assign pa = cnt[1] ? {1'b0, ma[52:27]} : ma[26:0];
  assign pb = cnt[0] ? {1'b0, mb[52:27]} : mb[26:0];

  always_comb begin
    case (pp_sh)
      2'd0:    pp_w = 128'(pp);
      2'd1:    pp_w = 128'(pp) << 27;
      2'd2:    pp_w = 128'(pp) << 54;
      default: pp_w = '0;
    endcase
  end

  assign be = x + 14'sd1023;
  assign sh = 14'sd1 - be;

  assign mant   = w[127:75];
  assign rnd_up = w[74] && ((w[73:0] != '0) || stk || mant[0]);
  assign mag    = {expm1, 52'b0} + 63'(mant) + 63'(rnd_up);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (req.start) begin
            op_r  <= req.op;
            a_r   <= req.a;
            b_r   <= req.b;
            state <= F_CHECK;
          end
        end
        F_CHECK: begin
          if (spec_hit) begin
            res   <= spec_val;
            state <= F_DONE;
          end else if (op_r == cce_pkg::FOP_MUL) begin
            sgn   <= mul_sign;
            x     <= 14'(effa) + 14'(effb) - 14'sd2023;
            w     <= '0;
            cnt   <= '0;
            stk   <= 1'b0;
            state <= F_PROD;
          end else begin
            w         <= {2'b00, mbig, 73'b0};
            w2        <= small_al;
            sgn       <= a_big ? a_r[63] : b_r[63];
            sgn_small <= a_big ? b_r[63] : a_r[63];
            sub       <= a_r[63] ^ b_r[63];
            x         <= 14'(effbig) - 14'sd1021;
            stk       <= 1'b0;
            state     <= F_ALIGN;
          end
        end
        F_PROD: begin
          if (cnt != 3'd0) w <= w + pp_w;
          if (cnt != 3'd4) begin
            pp    <= pa * pb;
            pp_sh <= 2'(cnt[1]) + 2'(cnt[0]);
            cnt   <= cnt + 3'd1;
          end else begin
            state <= F_NORM;
          end
        end
        F_ALIGN: begin
          if (!sub) begin
            w     <= w + w2;
            state <= F_NORM;
          end else if (w == w2) begin
            // Exact cancellation rounds to positive zero.
            res   <= '0;
            state <= F_DONE;
          end else if (w > w2) begin
            w     <= w - w2;
            state <= F_NORM;
          end else begin
            w     <= w2 - w;
            sgn   <= sgn_small;
            state <= F_NORM;
          end
        end
        F_NORM: begin
          if (w[127]) begin
            state <= F_SHIFT;
          end else if (w[127:112] == '0) begin
            w <= w << 16;
            x <= x - 14'sd16;
          end else begin
            w <= w << 1;
            x <= x - 14'sd1;
          end
        end
        F_SHIFT: begin
          if (be > 14'sd2046) begin
            res   <= {sgn, 11'h7FF, 52'b0};
            state <= F_DONE;
          end else if (be >= 14'sd1) begin
            expm1 <= 11'(be - 14'sd1);
            state <= F_ROUND;
          end else begin
            // Subnormal result: shift right, keep what falls off as sticky.
            expm1 <= '0;
            if (sh > 14'sd127) begin
              w   <= '0;
              stk <= 1'b1;
            end else begin
              w   <= w >> sh[6:0];
              stk <= (w & ~({128{1'b1}} << sh[6:0])) != '0;
            end
            state <= F_ROUND;
          end
        end
        F_ROUND: begin
          res   <= {sgn, mag};
          state <= F_DONE;
        end
        F_DONE: begin
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign rsp.done   = (state == F_DONE);
  assign rsp.result = res;

endmodule

// ===== dv/consider_covariance_engine_tb.sv =====
// ----------------------------------------------------------------------------
// Consider covariance engine testbench
// Loads P and C, streams weighted observation rows and finishes each run,
// checking every streamed element of P + T*C*T^T bit for bit against a
// binary64 predictor kept in a scoreboard, under random source and sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module consider_covariance_engine_tb;

  typedef struct {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [63:0] bits;
    logic        last;
  } element_t;

  class cov_scoreboard;
    int unsigned size_reg;
    int unsigned cons_reg;
    real         p_mat[cce_pkg::MAX_STATES][cce_pkg::MAX_STATES];
    real         c_mat[cce_pkg::MAX_CONSIDERS][cce_pkg::MAX_CONSIDERS];
    real         m_acc[cce_pkg::MAX_STATES][cce_pkg::MAX_CONSIDERS];
    real         hx_row[cce_pkg::MAX_STATES];
    real         hc_row[cce_pkg::MAX_CONSIDERS];
    element_t    pending_elems[$];
    int          errors;
    int          checked;

    function new();
      size_reg = 8;
      cons_reg = 4;
      errors   = 0;
      checked  = 0;
      foreach (m_acc[i, j]) m_acc[i][j] = 0.0;
    endfunction

    function int unsigned eff(int unsigned v, int unsigned lim);
      if (v < 1) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    function void set_reg(logic [1:0] idx, logic [3:0] data);
      if (idx == cce_pkg::REG_STATES) size_reg = 32'(data);
      else if (idx == cce_pkg::REG_CONSIDERS) cons_reg = 32'(data[2:0]);
    endfunction

    function void note_item(logic [2:0] kd, logic [2:0] r, logic [2:0] cl,
                            logic [63:0] bits);
      real v;
      real hw;
      real acc;
      real t[cce_pkg::MAX_STATES][cce_pkg::MAX_CONSIDERS];
      real s[cce_pkg::MAX_STATES][cce_pkg::MAX_CONSIDERS];
      int unsigned n;
      int unsigned c;
      element_t e;
      v = $bitstoreal(bits);
      n = eff(size_reg, cce_pkg::MAX_STATES);
      c = eff(cons_reg, cce_pkg::MAX_CONSIDERS);
      case (kd)
        cce_pkg::KIND_P: p_mat[r][cl] = v;
        cce_pkg::KIND_C:
          if (r < cce_pkg::MAX_CONSIDERS && cl < cce_pkg::MAX_CONSIDERS) c_mat[r][cl] = v;
        cce_pkg::KIND_HX: hx_row[cl] = v;
        cce_pkg::KIND_HC: if (cl < cce_pkg::MAX_CONSIDERS) hc_row[cl] = v;
        cce_pkg::KIND_COMMIT: begin
          for (int i = 0; i < n; i++) begin
            hw = hx_row[i] * v;
            for (int j = 0; j < c; j++) m_acc[i][j] = m_acc[i][j] + hw * hc_row[j];
          end
        end
        cce_pkg::KIND_FINISH: begin
          for (int i = 0; i < n; i++)
            for (int j = 0; j < c; j++) begin
              acc = 0.0;
              for (int k = 0; k < n; k++) acc = acc + p_mat[i][k] * m_acc[k][j];
              t[i][j] = acc;
            end
          for (int i = 0; i < n; i++)
            for (int j = 0; j < c; j++) begin
              acc = 0.0;
              for (int k = 0; k < c; k++) acc = acc + t[i][k] * c_mat[k][j];
              s[i][j] = acc;
            end
          for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
              acc = 0.0;
              for (int k = 0; k < c; k++) acc = acc + s[i][k] * t[j][k];
              e.row  = 3'(i);
              e.col  = 3'(j);
              e.bits = $realtobits(p_mat[i][j] + acc);
              e.last = (i == n - 1) && (j == n - 1);
              pending_elems = {pending_elems, e};
            end
          foreach (m_acc[i, j]) m_acc[i][j] = 0.0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [2:0] r, logic [2:0] cl, logic [63:0] bits,
                               logic last);
      element_t e;
      if (pending_elems.size() == 0) begin
        $display("%0t: unexpected element row %0d col %0d value %h", $time, r, cl, bits);
        errors++;
        return;
      end
      e = pending_elems.pop_front();
      checked++;
      if (r !== e.row) begin
        $display("%0t: out_row expected %0d actual %0d", $time, e.row, r);
        errors++;
      end
      if (cl !== e.col) begin
        $display("%0t: out_col expected %0d actual %0d", $time, e.col, cl);
        errors++;
      end
      if (bits !== e.bits) begin
        $display("%0t: out_value expected %h actual %h", $time, e.bits, bits);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_of_run expected %b actual %b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  kind = '0;
  logic [2:0]  row_index = '0;
  logic [2:0]  col_index = '0;
  logic [63:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_row;
  logic [2:0]  out_col;
  logic [63:0] out_value;
  logic        last_of_run;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;

  cov_scoreboard sb;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  items_sent = 0;
  int  runs_done = 0;

  always #6 clk = ~clk;

  consider_covariance_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .row_index(row_index), .col_index(col_index), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row(out_row), .out_col(out_col), .out_value(out_value),
    .last_of_run(last_of_run),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Sink side: checks each transfer and applies random or long stalls.
  // A requested long hold starts once the first result is on offer.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_row, out_col, out_value, last_of_run);
      if (hold_req && out_valid && hold_left == 0) begin
        hold_req = 1'b0;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [63:0] rand_val();
    if ($urandom_range(15) == 0) return {1'($urandom_range(1)), 63'd0};
    return {1'($urandom_range(1)), 11'($urandom_range(1031, 1015)),
            20'($urandom), 32'($urandom)};
  endfunction

  task automatic send_raw(logic [2:0] kd, logic [2:0] r, logic [2:0] cl, logic [63:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= kd;
    row_index <= r;
    col_index <= cl;
    value     <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_item(kd, r, cl, v);
    items_sent++;
  endtask

  task automatic send_item(cce_pkg::kind_t kd, int r, int cl, logic [63:0] v);
    send_raw(3'(kd), 3'(r), 3'(cl), v);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic drain(int limit_cycles);
    in_valid <= 1'b0;
    while (sb.pending_elems.size() != 0) @(posedge clk);
    repeat (limit_cycles) @(posedge clk);
  endtask

  // Unused storage, ignored kinds and out-of-range indices; none of it may
  // touch the entries that the current run reads.
  task automatic send_noise(int n, int c);
    case ($urandom_range(4))
      0: send_raw(3'd6 + 3'($urandom_range(1)), 3'($urandom), 3'($urandom),
                  {$urandom, $urandom});
      1: send_item(cce_pkg::KIND_C, $urandom_range(7, 4), $urandom_range(7),
                   {$urandom, $urandom});
      2: send_item(cce_pkg::KIND_HC, $urandom_range(7, 4), $urandom_range(7, 4),
                   {$urandom, $urandom});
      3: if (n < cce_pkg::MAX_STATES)
           send_item(cce_pkg::KIND_HX, $urandom_range(7), $urandom_range(7, n),
                     {$urandom, $urandom});
      default: if (n < cce_pkg::MAX_STATES)
           send_item(cce_pkg::KIND_P, $urandom_range(7, n), $urandom_range(7),
                     {$urandom, $urandom});
    endcase
  endtask

  task automatic run_estimate(int n_reg, int c_reg, int n_obs, bit noisy, bit hold);
    int n;
    int c;
    n = sb.eff(n_reg, cce_pkg::MAX_STATES);
    c = sb.eff(c_reg, cce_pkg::MAX_CONSIDERS);
    write_reg(cce_pkg::REG_STATES, 4'(n_reg));
    write_reg(cce_pkg::REG_CONSIDERS, 4'(c_reg));
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        send_item(cce_pkg::KIND_P, i, j, rand_val());
        if (noisy && $urandom_range(7) == 0) send_noise(n, c);
      end
    for (int i = 0; i < c; i++)
      for (int j = 0; j < c; j++) send_item(cce_pkg::KIND_C, i, j, rand_val());
    for (int o = 0; o < n_obs; o++) begin
      for (int i = 0; i < n; i++)
        send_item(cce_pkg::KIND_HX, $urandom_range(7), i, rand_val());
      for (int j = 0; j < c; j++)
        send_item(cce_pkg::KIND_HC, $urandom_range(7), j, rand_val());
      if (noisy && $urandom_range(3) == 0) send_noise(n, c);
      send_item(cce_pkg::KIND_COMMIT, $urandom_range(7), $urandom_range(7), rand_val());
    end
    if (hold) hold_req = 1'b1;
    send_item(cce_pkg::KIND_FINISH, $urandom_range(7), $urandom_range(7), rand_val());
    // Keep offering items while the sink holds off, so the input backs up.
    if (hold)
      for (int i = 0; i < 4; i++) send_item(cce_pkg::KIND_HX, 0, i, rand_val());
    runs_done++;
    drain(400);
  endtask

  initial begin
    int mode;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: smallest sizes from a zero register, register indices past
    // the list, a finish with no commits at full size from clamped registers.
    write_reg(2'd2, 4'hF);
    write_reg(2'd3, 4'h0);
    run_estimate(0, 0, 1, 1'b0, 1'b0);
    run_estimate(1, 1, 2, 1'b0, 1'b0);
    run_estimate(15, 7, 0, 1'b0, 1'b0);

    mode = 0;
    while (items_sent < 230 || mode < 4) begin
      case (mode % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 52; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 52; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      if ($urandom_range(9) == 0)
        run_estimate($urandom_range(8, 5), $urandom_range(4, 1), $urandom_range(2, 1),
                     1'b1, mode == 2);
      else
        run_estimate($urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(3, 0),
                     1'b1, mode == 2);
      mode++;
    end

    $display("Covered %0d input transfers over %0d estimate runs, %0d elements checked.",
             items_sent, runs_done, sb.checked);
    if (sb.errors == 0 && sb.pending_elems.size() == 0)
      $display("consider_covariance_engine regression: pass");
    else
      $display("consider_covariance_engine regression: fail");
    $finish;
  end

  initial begin
    #(64'd12 * 64'd50_000_000);
    $display("consider_covariance_engine regression: fail");
    $finish;
  end

endmodule
